FILE: design/bti_pkg.sv
package bti_pkg;

   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int LIM_W = 15;
   localparam int PIXEL_W = 8;
   localparam int LUMA_IDX_W = 24;
   localparam int CHROMA_IDX_W = 22;
   localparam int SUM_W = 18;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   localparam logic signed [8:0] K_Y_R = 9'sd66;
   localparam logic signed [8:0] K_Y_G = 9'sd129;
   localparam logic signed [8:0] K_Y_B = 9'sd25;
   localparam logic signed [8:0] K_U_R = -9'sd38;
   localparam logic signed [8:0] K_U_G = -9'sd74;
   localparam logic signed [8:0] K_U_B = 9'sd112;
   localparam logic signed [8:0] K_V_R = 9'sd112;
   localparam logic signed [8:0] K_V_G = -9'sd94;
   localparam logic signed [8:0] K_V_B = -9'sd18;

   localparam logic [PIXEL_W-1:0] LUMA_OFFSET = 8'd16;
   localparam logic [PIXEL_W-1:0] CHROMA_OFFSET = 8'd128;

   typedef struct packed {
      logic [PIXEL_W-1:0]      blue;
      logic [PIXEL_W-1:0]      green;
      logic [PIXEL_W-1:0]      red;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic                    chroma_valid;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_end;
   } entry_type;

   function automatic logic signed [SUM_W-1:0] weighted_sum(
      input logic [PIXEL_W-1:0] r,
      input logic [PIXEL_W-1:0] g,
      input logic [PIXEL_W-1:0] b,
      input logic signed [8:0]  kr,
      input logic signed [8:0]  kg,
      input logic signed [8:0]  kb
   );
      logic signed [SUM_W-1:0] pr;
      logic signed [SUM_W-1:0] pg;
      logic signed [SUM_W-1:0] pb;
      pr = $signed({1'b0, r}) * kr;
      pg = $signed({1'b0, g}) * kg;
      pb = $signed({1'b0, b}) * kb;
      return pr + pg + pb;
   endfunction

endpackage

FILE: design/bgra_to_i420_frame_converter_unit.sv
// Converts a raster stream of BGRA pixels, one per transaction, into I420 samples: every
// pixel gives a BT.601 studio-range luma and its luma-plane position, and the top-left
// pixel of each 2x2 block also gives Cb, Cr and a chroma-plane position. The block takes
// one pixel per clock and delivers one result per clock unless stalled; an accepted
// pixel passes the queue, the weighted-sum and output registers in turn. A four-entry
// queue between the counting front end and the arithmetic back end absorbs result-side
// stalls, so req_stall rises only once that queue is full. The user must write frame
// width and height via the csr_ port while no pixel is in flight; the block won't check.
module bgra_to_i420_frame_converter_unit import bti_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIXEL_W-1:0]      req_blue,
   input  logic [PIXEL_W-1:0]      req_green,
   input  logic [PIXEL_W-1:0]      req_red,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIXEL_W-1:0]      rsp_luma,
   output logic [LUMA_IDX_W-1:0]   rsp_luma_index,
   output logic                    rsp_chroma_valid,
   output logic [PIXEL_W-1:0]      rsp_blue_diff,
   output logic [PIXEL_W-1:0]      rsp_red_diff,
   output logic [CHROMA_IDX_W-1:0] rsp_chroma_index,
   output logic                    rsp_frame_end
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic      q_full;
   logic      q_push;
   entry_type q_push_data;
   logic      q_pop;
   logic      q_valid;
   entry_type q_data;

   bti_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .COL_W     (COL_W),
      .ROW_W     (ROW_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   bti_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .out_valid(q_valid),
      .out_data (q_data)
   );

   bti_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_luma        (rsp_luma),
      .rsp_luma_index  (rsp_luma_index),
      .rsp_chroma_valid(rsp_chroma_valid),
      .rsp_blue_diff   (rsp_blue_diff),
      .rsp_red_diff    (rsp_red_diff),
      .rsp_chroma_index(rsp_chroma_index),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

FILE: design/bti_queue.sv
module bti_queue import bti_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      out_valid,
   output entry_type out_data
);

   entry_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_CNT_W-1:0] count_in;

   assign full = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("Queue holds more transactions than its depth.");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + Q_CNT_W'(1))
      else $error("Queue count did not grow on a lone push.");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - Q_CNT_W'(1))
      else $error("Queue count did not shrink on a lone pop.");
`endif

endmodule

FILE: design/bti_front.sv
module bti_front import bti_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int COL_W = 12,
   parameter int ROW_W = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_blue,
   input  logic [PIXEL_W-1:0]     req_green,
   input  logic [PIXEL_W-1:0]     req_red,
   input  logic                   q_full,
   output logic                   q_push,
   output entry_type              q_push_data
);

   localparam logic [LIM_W-1:0] WIDTH_CAP = LIM_W'(MAX_WIDTH & ~1);
   localparam logic [LIM_W-1:0] HEIGHT_CAP = LIM_W'(MAX_HEIGHT);

   function automatic logic [LIM_W-1:0] last_col_of(input logic [CSR_DATA_W-1:0] v);
      logic [LIM_W-1:0] w;
      w = LIM_W'({v[CSR_DATA_W-1:1], 1'b0});
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      if (w < LIM_W'(2)) w = LIM_W'(2);
      return w - LIM_W'(1);
   endfunction

   function automatic logic [LIM_W-1:0] last_row_of(input logic [CSR_DATA_W-1:0] v);
      logic [LIM_W-1:0] h;
      h = LIM_W'(v);
      if (h > HEIGHT_CAP) h = HEIGHT_CAP;
      if (h < LIM_W'(1)) h = LIM_W'(1);
      return h - LIM_W'(1);
   endfunction

   logic [LIM_W-1:0]        last_col_ff;
   logic [LIM_W-1:0]        last_row_ff;
   logic [COL_W-1:0]        column_ff;
   logic [COL_W-1:0]        column_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic [LUMA_IDX_W-1:0]   luma_count_ff;
   logic [LUMA_IDX_W-1:0]   luma_count_in;
   logic [CHROMA_IDX_W-1:0] chroma_count_ff;
   logic [CHROMA_IDX_W-1:0] chroma_count_in;
   logic                    accept;
   logic                    chroma_valid;
   logic                    row_end;
   logic                    frame_end;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign q_push = accept;

   always_comb begin
      chroma_valid = !row_ff[0] && !column_ff[0];
      row_end = LIM_W'(column_ff) >= last_col_ff;
      frame_end = row_end && (LIM_W'(row_ff) >= last_row_ff);

      q_push_data.blue = req_blue;
      q_push_data.green = req_green;
      q_push_data.red = req_red;
      q_push_data.luma_index = luma_count_ff;
      q_push_data.chroma_valid = chroma_valid;
      q_push_data.chroma_index = chroma_valid ? chroma_count_ff : '0;
      q_push_data.frame_end = frame_end;

      column_in = column_ff;
      row_in = row_ff;
      luma_count_in = luma_count_ff;
      chroma_count_in = chroma_count_ff;
      if (accept) begin
         luma_count_in = luma_count_ff + LUMA_IDX_W'(1);
         if (chroma_valid) begin
            chroma_count_in = chroma_count_ff + CHROMA_IDX_W'(1);
         end
         if (frame_end) begin
            column_in = '0;
            row_in = '0;
            luma_count_in = '0;
            chroma_count_in = '0;
         end else if (row_end) begin
            column_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= last_col_of(FRAME_WIDTH_RESET);
         last_row_ff <= last_row_of(FRAME_HEIGHT_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               last_col_ff <= last_col_of(csr_write_data);
            end
            REG_FRAME_HEIGHT: begin
               last_row_ff <= last_row_of(csr_write_data);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff <= '0;
         luma_count_ff <= '0;
         chroma_count_ff <= '0;
      end else begin
         column_ff <= column_in;
         row_ff <= row_in;
         luma_count_ff <= luma_count_in;
         chroma_count_ff <= chroma_count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (column_ff == '0) && (row_ff == '0)
         && (luma_count_ff == '0) && (chroma_count_ff == '0))
      else $error("Counters did not restart after the last pixel of a frame.");

   a_luma_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !frame_end) |=> luma_count_ff == $past(luma_count_ff) + LUMA_IDX_W'(1))
      else $error("Luma position did not advance by one.");
`endif

endmodule

FILE: design/bti_back.sv
module bti_back import bti_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  entry_type               q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIXEL_W-1:0]      rsp_luma,
   output logic [LUMA_IDX_W-1:0]   rsp_luma_index,
   output logic                    rsp_chroma_valid,
   output logic [PIXEL_W-1:0]      rsp_blue_diff,
   output logic [PIXEL_W-1:0]      rsp_red_diff,
   output logic [CHROMA_IDX_W-1:0] rsp_chroma_index,
   output logic                    rsp_frame_end
);

   typedef struct packed {
      logic signed [SUM_W-1:0] y_sum;
      logic signed [SUM_W-1:0] u_sum;
      logic signed [SUM_W-1:0] v_sum;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic                    chroma_valid;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_end;
   } sums_type;

   logic                    advance;
   logic                    s1_valid_ff;
   sums_type                s1_ff;
   sums_type                s1_in;
   logic                    out_valid_ff;
   logic [PIXEL_W-1:0]      luma_ff;
   logic [PIXEL_W-1:0]      luma_in;
   logic [LUMA_IDX_W-1:0]   luma_index_ff;
   logic                    chroma_valid_ff;
   logic [PIXEL_W-1:0]      blue_diff_ff;
   logic [PIXEL_W-1:0]      blue_diff_in;
   logic [PIXEL_W-1:0]      red_diff_ff;
   logic [PIXEL_W-1:0]      red_diff_in;
   logic [CHROMA_IDX_W-1:0] chroma_index_ff;
   logic                    frame_end_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop = advance && q_valid;

   always_comb begin
      s1_in.y_sum = weighted_sum(q_data.red, q_data.green, q_data.blue, K_Y_R, K_Y_G, K_Y_B);
      s1_in.u_sum = weighted_sum(q_data.red, q_data.green, q_data.blue, K_U_R, K_U_G, K_U_B);
      s1_in.v_sum = weighted_sum(q_data.red, q_data.green, q_data.blue, K_V_R, K_V_G, K_V_B);
      s1_in.luma_index = q_data.luma_index;
      s1_in.chroma_valid = q_data.chroma_valid;
      s1_in.chroma_index = q_data.chroma_index;
      s1_in.frame_end = q_data.frame_end;

      luma_in = s1_ff.y_sum[15:8] + LUMA_OFFSET;
      blue_diff_in = s1_ff.chroma_valid ? s1_ff.u_sum[15:8] + CHROMA_OFFSET : '0;
      red_diff_in = s1_ff.chroma_valid ? s1_ff.v_sum[15:8] + CHROMA_OFFSET : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= q_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         luma_ff <= luma_in;
         luma_index_ff <= s1_ff.luma_index;
         chroma_valid_ff <= s1_ff.chroma_valid;
         blue_diff_ff <= blue_diff_in;
         red_diff_ff <= red_diff_in;
         chroma_index_ff <= s1_ff.chroma_index;
         frame_end_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_luma = luma_ff;
   assign rsp_luma_index = luma_index_ff;
   assign rsp_chroma_valid = chroma_valid_ff;
   assign rsp_blue_diff = blue_diff_ff;
   assign rsp_red_diff = red_diff_ff;
   assign rsp_chroma_index = chroma_index_ff;
   assign rsp_frame_end = frame_end_ff;

`ifndef NO_ASSERTIONS
   a_no_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !chroma_valid_ff) |->
         (blue_diff_ff == '0) && (red_diff_ff == '0) && (chroma_index_ff == '0))
      else $error("Chroma fields are not zero on a pixel without chroma.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("Product stage dropped a transaction while stalled.");
`endif

endmodule

FILE: bench/bgra_to_i420_frame_converter_checker.sv
`timescale 1ns / 100ps

module bgra_to_i420_frame_converter_checker import bti_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [PIXEL_W-1:0]      req_blue,
   input  logic [PIXEL_W-1:0]      req_green,
   input  logic [PIXEL_W-1:0]      req_red,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [PIXEL_W-1:0]      rsp_luma,
   input  logic [LUMA_IDX_W-1:0]   rsp_luma_index,
   input  logic                    rsp_chroma_valid,
   input  logic [PIXEL_W-1:0]      rsp_blue_diff,
   input  logic [PIXEL_W-1:0]      rsp_red_diff,
   input  logic [CHROMA_IDX_W-1:0] rsp_chroma_index,
   input  logic                    rsp_frame_end,
   output int                      error_count,
   output int                      pending_count,
   output int                      results_checked,
   output int                      chroma_results
);

   typedef struct packed {
      logic [PIXEL_W-1:0]      luma;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic                    chroma_valid;
      logic [PIXEL_W-1:0]      blue_diff;
      logic [PIXEL_W-1:0]      red_diff;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_end;
   } yuv_sample_type;

   yuv_sample_type          expected_samples[$];
   logic [CSR_DATA_W-1:0]   width_reg;
   logic [CSR_DATA_W-1:0]   height_reg;
   logic [11:0]             column;
   logic [11:0]             row;
   logic [LUMA_IDX_W-1:0]   luma_pos;
   logic [CHROMA_IDX_W-1:0] chroma_pos;

   initial begin
      error_count = 0;
      results_checked = 0;
      chroma_results = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input int unsigned seen_value,
                              input int unsigned wanted_value, input int unsigned position);
      if (seen_value != wanted_value) begin
         report_mismatch($sformatf("%s is %0d, expected %0d (luma index %0d)",
                                   name, seen_value, wanted_value, position));
      end
   endtask

   // Works out the samples for one pixel and advances the raster position.
   function automatic yuv_sample_type convert_pixel(input logic [PIXEL_W-1:0] blue,
                                                    input logic [PIXEL_W-1:0] green,
                                                    input logic [PIXEL_W-1:0] red);
      yuv_sample_type predicted;
      int             r;
      int             g;
      int             b;
      int             w;
      int             h;
      logic           row_done;
      logic           last_pixel;
      r = red;
      g = green;
      b = blue;
      w = width_reg & 13'h1FFE;
      if (w > (MAX_WIDTH & ~1)) w = MAX_WIDTH & ~1;
      if (w < 2) w = 2;
      h = height_reg;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (h < 1) h = 1;
      predicted = '0;
      predicted.chroma_valid = !row[0] && !column[0];
      row_done = int'(column) >= w - 1;
      last_pixel = row_done && (int'(row) >= h - 1);
      predicted.luma = 8'(((66 * r + 129 * g + 25 * b) >>> 8) + 16);
      predicted.luma_index = luma_pos;
      if (predicted.chroma_valid) begin
         predicted.blue_diff = 8'(((-38 * r - 74 * g + 112 * b) >>> 8) + 128);
         predicted.red_diff = 8'(((112 * r - 94 * g - 18 * b) >>> 8) + 128);
         predicted.chroma_index = chroma_pos;
         chroma_pos = chroma_pos + 1'b1;
      end
      predicted.frame_end = last_pixel;
      luma_pos = luma_pos + 1'b1;
      if (last_pixel) begin
         column = '0;
         row = '0;
         luma_pos = '0;
         chroma_pos = '0;
      end else if (row_done) begin
         column = '0;
         row = row + 1'b1;
      end else begin
         column = column + 1'b1;
      end
      return predicted;
   endfunction

   always @(posedge clock) begin : watch
      yuv_sample_type seen;
      yuv_sample_type wanted;
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         column = '0;
         row = '0;
         luma_pos = '0;
         chroma_pos = '0;
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_reg = csr_write_data;
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_luma, rsp_luma_index, rsp_chroma_valid, rsp_blue_diff,
                    rsp_red_diff, rsp_chroma_index, rsp_frame_end};
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("result with luma index %0d arrived with no pixel pending",
                                         seen.luma_index));
            end else begin
               wanted = expected_samples.pop_front();
               check_field("luma", seen.luma, wanted.luma, wanted.luma_index);
               check_field("luma_index", seen.luma_index, wanted.luma_index, wanted.luma_index);
               check_field("chroma_valid", seen.chroma_valid, wanted.chroma_valid,
                           wanted.luma_index);
               check_field("blue_diff", seen.blue_diff, wanted.blue_diff, wanted.luma_index);
               check_field("red_diff", seen.red_diff, wanted.red_diff, wanted.luma_index);
               check_field("chroma_index", seen.chroma_index, wanted.chroma_index,
                           wanted.luma_index);
               check_field("frame_end", seen.frame_end, wanted.frame_end, wanted.luma_index);
               results_checked++;
               if (wanted.chroma_valid) chroma_results++;
            end
         end
         if (req_valid && !req_stall) begin
            expected_samples.push_back(convert_pixel(req_blue, req_green, req_red));
         end
      end
      pending_count <= expected_samples.size();
   end

endmodule

FILE: bench/bgra_to_i420_frame_converter_unit_tb.sv
`timescale 1ns / 100ps

module bgra_to_i420_frame_converter_unit_tb;
   import bti_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [PIXEL_W-1:0]      req_blue = '0;
   logic [PIXEL_W-1:0]      req_green = '0;
   logic [PIXEL_W-1:0]      req_red = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]      rsp_luma;
   logic [LUMA_IDX_W-1:0]   rsp_luma_index;
   logic                    rsp_chroma_valid;
   logic [PIXEL_W-1:0]      rsp_blue_diff;
   logic [PIXEL_W-1:0]      rsp_red_diff;
   logic [CHROMA_IDX_W-1:0] rsp_chroma_index;
   logic                    rsp_frame_end;

   int error_count;
   int pending_count;
   int results_checked;
   int chroma_results;
   int pixels_sent = 0;
   int geometry_count = 0;

   bgra_to_i420_frame_converter_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_blue(req_blue),
      .req_green(req_green),
      .req_red(req_red),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_luma(rsp_luma),
      .rsp_luma_index(rsp_luma_index),
      .rsp_chroma_valid(rsp_chroma_valid),
      .rsp_blue_diff(rsp_blue_diff),
      .rsp_red_diff(rsp_red_diff),
      .rsp_chroma_index(rsp_chroma_index),
      .rsp_frame_end(rsp_frame_end)
   );

   bgra_to_i420_frame_converter_checker u_checker (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_blue(req_blue),
      .req_green(req_green),
      .req_red(req_red),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_luma(rsp_luma),
      .rsp_luma_index(rsp_luma_index),
      .rsp_chroma_valid(rsp_chroma_valid),
      .rsp_blue_diff(rsp_blue_diff),
      .rsp_red_diff(rsp_red_diff),
      .rsp_chroma_index(rsp_chroma_index),
      .rsp_frame_end(rsp_frame_end),
      .error_count(error_count),
      .pending_count(pending_count),
      .results_checked(results_checked),
      .chroma_results(chroma_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [PIXEL_W-1:0] random_byte();
      case ($urandom_range(15))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // The sender adds no random gaps while the quiet stretch of transactions is under way.
   task automatic send_pixel(input logic [PIXEL_W-1:0] blue, input logic [PIXEL_W-1:0] green,
                             input logic [PIXEL_W-1:0] red);
      if ((pixels_sent < 600 || pixels_sent >= 900) && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_blue <= blue;
      req_green <= green;
      req_red <= red;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_count != 0 && waited < 4000);
   endtask

   task automatic write_geometry(input logic [CSR_DATA_W-1:0] width,
                                 input logic [CSR_DATA_W-1:0] height);
      csr_write_enable <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_geometry(input logic [CSR_DATA_W-1:0] width,
                               input logic [CSR_DATA_W-1:0] height, input int count);
      wait_for_results();
      write_geometry(width, height);
      geometry_count++;
      repeat (count) send_pixel(random_byte(), random_byte(), random_byte());
   endtask

   // At result 250 and each 500 on, the receiver holds off so the block fills and stalls.
   initial begin : receiver
      int taken;
      int hold;
      taken = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
            if (taken % 500 == 250) hold = 64;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (taken >= 600 && taken < 900) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 10);
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      geometry_count = 1;

      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'h00);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel(8'h01, 8'h80, 8'hFE);

      run_geometry(13'd4, 13'd3, 40);
      run_geometry(13'd2, 13'd1, 40);
      run_geometry(13'd0, 13'd0, 30);
      run_geometry(13'd1, 13'd8191, 40);
      run_geometry(13'd3, 13'd3, 40);
      run_geometry(13'd8191, 13'd1, 100);
      run_geometry(13'd4096, 13'd4096, 100);
      run_geometry(13'd6, 13'd2, 60);
      run_geometry(13'd16, 13'd5, 300);
      repeat (6) begin
         run_geometry(13'($urandom_range(0, 40)), 13'($urandom_range(0, 9)),
                      $urandom_range(80, 160));
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Run covered %0d pixels over %0d frame geometries, including tiny, odd and",
               pixels_sent, geometry_count);
      $display("saturated sizes; %0d results compared, %0d of them with chroma.",
               results_checked, chroma_results);
      if (pending_count != 0) begin
         $display("%0d expected results never arrived.", pending_count);
      end
      if (error_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Run timed out.");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
design/bti_pkg.sv
design/bti_queue.sv
design/bti_front.sv
design/bti_back.sv
design/bgra_to_i420_frame_converter_unit.sv
bench/bgra_to_i420_frame_converter_checker.sv
bench/bgra_to_i420_frame_converter_unit_tb.sv
